// ===== design/hsc_pkg.sv =====
`timescale 1ns / 1ps
// hsc_pkg: shared types, constants and codeword-layout functions
// for the SECDED codec. No dependencies.
package hsc_pkg;

    localparam int MAX_DATA_BITS_DEF = 64;
    localparam int LEN_W             = 7;
    localparam int SYN_W             = 7;
    localparam int CHK_W             = 8;
    localparam int CNT_W             = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAN  = 2'd0,
        ST_SINGLE = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [SYN_W-1:0] syn;
        logic             par;
    } t_syn_info;

    // codeword position of data bit idx: idx-th non-power-of-two position from 3
    function automatic logic [SYN_W-1:0] data_pos(input int unsigned idx);
        int unsigned cnt;
        logic [SYN_W-1:0] res;
        cnt = 0;
        res = '0;
        for (int q = 3; q < 128; q++) begin
            if ((q & (q - 1)) != 0) begin
                if (cnt == idx) begin
                    res = SYN_W'(q);
                end
                cnt++;
            end
        end
        return res;
    endfunction

    // smallest r with 2^r >= len + r + 1
    function automatic logic [CNT_W-1:0] parity_count(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] r;
        r = CNT_W'(7);
        for (int k = 6; k >= 1; k--) begin
            if ((8'd1 << k) >= (8'(len) + 8'(k) + 8'd1)) begin
                r = CNT_W'(k);
            end
        end
        return r;
    endfunction

endpackage

// ===== design/hsc_syndrome.sv =====
`timescale 1ns / 1ps
// hsc_syndrome: masks the data word to the active length and folds the
// positions of its set bits into a syndrome and parity. Uses hsc_pkg.
module hsc_syndrome #(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
    input  logic [MAX_DATA_BITS-1:0]    i_data,
    input  logic [hsc_pkg::LEN_W-1:0]   i_len,
    output logic [MAX_DATA_BITS-1:0]    o_data_m,
    output hsc_pkg::t_syn_info          o_info
);
    import hsc_pkg::*;

    logic [SYN_W-1:0] contrib [MAX_DATA_BITS];
    logic [SYN_W-1:0] syn;

    for (genvar g = 0; g < MAX_DATA_BITS; g++) begin : g_bit
        localparam logic [SYN_W-1:0] POS = data_pos(g);
        assign o_data_m[g] = i_data[g] & (LEN_W'(g) < i_len);
        assign contrib[g]  = {SYN_W{o_data_m[g]}} & POS;
    end

    always_comb begin
        syn = '0;
        for (int d = 0; d < MAX_DATA_BITS; d++) begin
            syn = syn ^ contrib[d];
        end
    end

    assign o_info.syn = syn;
    assign o_info.par = ^o_data_m;

endmodule

// ===== design/hsc_resolve.sv =====
`timescale 1ns / 1ps
// hsc_resolve: builds check bits on encode; on decode classifies the
// syndrome and corrects a single error. Uses hsc_pkg.
module hsc_resolve #(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
    input  logic                        i_req,
    input  logic [MAX_DATA_BITS-1:0]    i_data_m,
    input  logic [hsc_pkg::CHK_W-1:0]   i_chk,
    input  logic [hsc_pkg::LEN_W-1:0]   i_len,
    input  hsc_pkg::t_syn_info          i_info,
    output logic [MAX_DATA_BITS-1:0]    o_data,
    output logic [hsc_pkg::CHK_W-1:0]   o_chk,
    output hsc_pkg::t_status            o_status,
    output logic [hsc_pkg::SYN_W-1:0]   o_epos
);
    import hsc_pkg::*;

    logic [CNT_W-1:0]         p_cnt;
    logic [LEN_W-1:0]         cw_len;
    logic [SYN_W-1:0]         rmask;
    logic [CHK_W-1:0]         chk_m;
    logic [SYN_W-1:0]         pbits;
    logic [SYN_W-1:0]         syn_d;
    logic                     par_d;
    logic [MAX_DATA_BITS-1:0] hit;

    assign p_cnt  = parity_count(i_len);
    assign cw_len = i_len + LEN_W'(p_cnt) + LEN_W'(1);
    assign rmask  = SYN_W'((8'd1 << p_cnt) - 8'd1);
    assign chk_m  = i_chk & {rmask, 1'b1};
    assign pbits  = i_info.syn & rmask;
    assign syn_d  = i_info.syn ^ chk_m[CHK_W-1:1];
    assign par_d  = i_info.par ^ (^chk_m);

    for (genvar g = 0; g < MAX_DATA_BITS; g++) begin : g_hit
        localparam logic [SYN_W-1:0] POS = data_pos(g);
        assign hit[g] = (syn_d == POS);
    end

    always_comb begin
        o_data   = i_data_m;
        o_chk    = chk_m;
        o_status = ST_CLEAN;
        o_epos   = '0;
        if (i_req == REQ_ENCODE) begin
            o_chk = {pbits, i_info.par ^ (^pbits)};
        end else if (!par_d) begin
            if (syn_d != '0) begin
                o_status = ST_DOUBLE;
            end
        end else if (syn_d >= cw_len) begin
            o_status = ST_RANGE;
            o_epos   = syn_d;
        end else begin
            o_status = ST_SINGLE;
            o_epos   = syn_d;
            if (syn_d == '0) begin
                o_chk[0] = ~chk_m[0];
            end else begin
                for (int k = 0; k < SYN_W; k++) begin
                    if (syn_d == (SYN_W'(1) << k)) begin
                        o_chk[k+1] = ~chk_m[k+1];
                    end
                end
                o_data = i_data_m ^ hit;
            end
        end
    end

endmodule

// ===== design/hamming_secded_codec.sv =====
`timescale 1ns / 1ps
// hamming_secded_codec: top level of the extended Hamming SECDED codec.
// Uses hsc_pkg, hsc_syndrome and hsc_resolve.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | i_valid / o_stall    | i_req_type, i_data_bits, i_check_bits
//  result   | o_valid / i_stall    | o_out_data, o_out_check, o_status,
//           |                      | o_error_position
//  config   | i_cfg_wr_en          | i_cfg_wr_data (data_length)
//
// Two register stages: request register, then result register. One transfer
// per cycle sustained while the result is not stalled; a request is held in
// the request register and its result is registered into the result register.
// Synchronous active-low reset clears both valid bits and sets length to 64.
// A stalled result holds; the request stage keeps accepting while either
// stage has room.
module hamming_secded_codec #(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [hsc_pkg::LEN_W-1:0]   i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_req_type,
    input  logic [MAX_DATA_BITS-1:0]    i_data_bits,
    input  logic [hsc_pkg::CHK_W-1:0]   i_check_bits,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [MAX_DATA_BITS-1:0]    o_out_data,
    output logic [hsc_pkg::CHK_W-1:0]   o_out_check,
    output logic [1:0]                  o_status,
    output logic [hsc_pkg::SYN_W-1:0]   o_error_position
);
    import hsc_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DATA_BITS);

    logic [LEN_W-1:0]         r_cfg_len;
    logic [LEN_W-1:0]         eff_len;

    logic                     r_in_vld;
    logic                     r_in_req;
    logic [MAX_DATA_BITS-1:0] r_in_data;
    logic [CHK_W-1:0]         r_in_chk;

    logic                     r_out_vld;
    logic                     r_out_req;
    logic [MAX_DATA_BITS-1:0] r_out_data;
    logic [CHK_W-1:0]         r_out_chk;
    t_status                  r_out_status;
    logic [SYN_W-1:0]         r_out_epos;

    logic                     adv_out;
    logic                     accept;

    logic [MAX_DATA_BITS-1:0] data_m;
    t_syn_info                syn_info;
    logic [MAX_DATA_BITS-1:0] n_data;
    logic [CHK_W-1:0]         n_chk;
    t_status                  n_status;
    logic [SYN_W-1:0]         n_epos;

    always_comb begin
        eff_len = r_cfg_len;
        if (r_cfg_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_cfg_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end
    end

    assign adv_out = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !adv_out;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (adv_out) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_req  <= i_req_type;
            r_in_data <= i_data_bits;
            r_in_chk  <= i_check_bits;
        end
        if (r_in_vld && adv_out) begin
            r_out_req    <= r_in_req;
            r_out_data   <= n_data;
            r_out_chk    <= n_chk;
            r_out_status <= n_status;
            r_out_epos   <= n_epos;
        end
    end

    hsc_syndrome #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_syndrome (
        .i_data   (r_in_data),
        .i_len    (eff_len),
        .o_data_m (data_m),
        .o_info   (syn_info)
    );

    hsc_resolve #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_resolve (
        .i_req    (r_in_req),
        .i_data_m (data_m),
        .i_chk    (r_in_chk),
        .i_len    (eff_len),
        .i_info   (syn_info),
        .o_data   (n_data),
        .o_chk    (n_chk),
        .o_status (n_status),
        .o_epos   (n_epos)
    );

    assign o_valid          = r_out_vld;
    assign o_out_data       = r_out_data;
    assign o_out_check      = r_out_chk;
    assign o_status         = r_out_status;
    assign o_error_position = r_out_epos;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv_out |=> r_in_vld)
        else $error("request lost while result stage blocked");

    a_encode_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_req == REQ_ENCODE |->
            r_out_status == ST_CLEAN && r_out_epos == '0)
        else $error("encode result carries error status");

    a_epos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out_status == ST_CLEAN || r_out_status == ST_DOUBLE) |->
            r_out_epos == '0)
        else $error("error position set without single or range status");

endmodule

// ===== verif/hamming_secded_codec_tb.sv =====
`timescale 1ns / 1ps
// hamming_secded_codec_tb: self-checking bench for the SECDED codec, a directed table
// followed by random encodes, codewords with zero, one or two flipped bits and noise.
// Depends on hsc_pkg and the hamming_secded_codec RTL.
module hamming_secded_codec_tb;
    import hsc_pkg::*;

    localparam int DATA_W = MAX_DATA_BITS_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CHK_W-1:0]  check;
        t_status           status;
        logic [SYN_W-1:0]  epos;
    } t_codec_result;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              req;
        logic [DATA_W-1:0] data;
        logic [CHK_W-1:0]  check;
        logic              typed;
        t_codec_result     want;
    } t_dir_row;

    localparam int DIR_ROWS = 23;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{7'd64, REQ_ENCODE, 64'd0, 8'h00, 1'b1, '{64'd0, 8'h00, ST_CLEAN, 7'd0}},
        '{7'd64, REQ_DECODE, 64'd0, 8'h00, 1'b1, '{64'd0, 8'h00, ST_CLEAN, 7'd0}},
        '{7'd64, REQ_DECODE, 64'd0, 8'h01, 1'b1, '{64'd0, 8'h00, ST_SINGLE, 7'd0}},
        '{7'd64, REQ_DECODE, 64'd0, 8'h02, 1'b1, '{64'd0, 8'h00, ST_SINGLE, 7'd1}},
        '{7'd64, REQ_DECODE, 64'd1, 8'h00, 1'b1, '{64'd0, 8'h00, ST_SINGLE, 7'd3}},
        '{7'd64, REQ_DECODE, 64'd0, 8'h03, 1'b1, '{64'd0, 8'h03, ST_DOUBLE, 7'd0}},
        '{7'd64, REQ_DECODE, 64'd0, 8'h80, 1'b1, '{64'd0, 8'h00, ST_SINGLE, 7'd64}},
        '{7'd64, REQ_DECODE, 64'd0, 8'h91, 1'b1, '{64'd0, 8'h91, ST_RANGE, 7'd72}},
        '{7'd64, REQ_ENCODE, {64{1'b1}}, 8'hFF, 1'b0, '0},
        '{7'd64, REQ_DECODE, {64{1'b1}}, 8'hFF, 1'b0, '0},
        '{7'd64, REQ_DECODE, 64'h8000_0000_0000_0000, 8'h00, 1'b1,
          '{64'd0, 8'h00, ST_SINGLE, 7'd71}},
        '{7'd64, REQ_ENCODE, 64'hA5A5_A5A5_5A5A_5A5A, 8'h5A, 1'b0, '0},
        '{7'd127, REQ_ENCODE, {64{1'b1}}, 8'h00, 1'b0, '0},
        '{7'd127, REQ_DECODE, 64'd0, 8'h91, 1'b1, '{64'd0, 8'h91, ST_RANGE, 7'd72}},
        '{7'd0, REQ_ENCODE, {64{1'b1}}, 8'hFF, 1'b1, '{64'd1, 8'h07, ST_CLEAN, 7'd0}},
        '{7'd0, REQ_DECODE, 64'd0, 8'hFF, 1'b1, '{64'd1, 8'h07, ST_SINGLE, 7'd3}},
        '{7'd1, REQ_ENCODE, 64'hFFFF_FFFF_FFFF_FFFE, 8'hFF, 1'b1,
          '{64'd0, 8'h00, ST_CLEAN, 7'd0}},
        '{7'd1, REQ_DECODE, 64'd1, 8'h07, 1'b1, '{64'd1, 8'h07, ST_CLEAN, 7'd0}},
        '{7'd5, REQ_DECODE, 64'd0, 8'h1F, 1'b1, '{64'd0, 8'h1F, ST_RANGE, 7'd15}},
        '{7'd5, REQ_ENCODE, 64'h0000_0000_0000_001F, 8'h00, 1'b0, '0},
        '{7'd65, REQ_DECODE, 64'h0123_4567_89AB_CDEF, 8'h3C, 1'b0, '0},
        '{7'd64, REQ_ENCODE, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, '0},
        '{7'd64, REQ_DECODE, {64{1'b1}}, 8'h00, 1'b0, '0}
    };

    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 75;
    localparam logic [LEN_W-1:0] PHASE_LEN [PHASES] = '{
        7'd1, 7'd64, 7'd2, 7'd63, 7'd4, 7'd5, 7'd11, 7'd26, 7'd57, 7'd0, 7'd127, 7'd33
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]  i_cfg_wr_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_req_type = REQ_ENCODE;
    logic [DATA_W-1:0] i_data_bits = '0;
    logic [CHK_W-1:0]  i_check_bits = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [DATA_W-1:0] o_out_data;
    logic [CHK_W-1:0]  o_out_check;
    logic [1:0]        o_status;
    logic [SYN_W-1:0]  o_error_position;

    t_codec_result    codec_results_due[$];
    logic [LEN_W-1:0] cur_len = LEN_RESET;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               fail_count = 0;

    hamming_secded_codec #(
        .MAX_DATA_BITS(DATA_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_data_bits(i_data_bits),
        .i_check_bits(i_check_bits),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out_data(o_out_data),
        .o_out_check(o_out_check),
        .o_status(o_status),
        .o_error_position(o_error_position)
    );

    always #6 i_clk = ~i_clk;

    // effective data length and Hamming parity count for a register value
    function automatic void codeword_dims(input logic [LEN_W-1:0] cfg_len,
                                          output int unsigned len, output int unsigned np);
        len = cfg_len;
        if (len == 0) len = 1;
        if (len > DATA_W) len = DATA_W;
        np = 0;
        while ((1 << np) < len + np + 1) np++;
    endfunction

    function automatic t_codec_result secded_compute(input logic [LEN_W-1:0] cfg_len,
                                                     input logic req,
                                                     input logic [DATA_W-1:0] din,
                                                     input logic [CHK_W-1:0] cin);
        int unsigned len, np, n, syn, par, d;
        t_codec_result res;
        codeword_dims(cfg_len, len, np);
        n = len + np + 1;
        res.data = din & ({DATA_W{1'b1}} >> (DATA_W - len));
        res.check = cin & CHK_W'((1 << (np + 1)) - 1);
        res.status = ST_CLEAN;
        res.epos = '0;
        syn = 0;
        par = 0;
        d = 0;
        for (int p = 3; p < n; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (res.data[d]) begin
                    syn ^= p;
                    par ^= 1;
                end
                d++;
            end
        end
        if (req == REQ_ENCODE) begin
            syn &= (1 << np) - 1;
            par ^= $countones(syn) & 1;
            res.check = CHK_W'((syn << 1) | (par & 1));
        end else begin
            for (int k = 0; k < np; k++) begin
                if (res.check[k+1]) begin
                    syn ^= 1 << k;
                    par ^= 1;
                end
            end
            par ^= res.check[0];
            if (par == 0) begin
                if (syn != 0) res.status = ST_DOUBLE;
            end else if (syn >= n) begin
                res.status = ST_RANGE;
                res.epos = SYN_W'(syn);
            end else begin
                res.status = ST_SINGLE;
                res.epos = SYN_W'(syn);
                if (syn == 0) begin
                    res.check[0] = ~res.check[0];
                end else if ((syn & (syn - 1)) == 0) begin
                    for (int k = 0; k < np; k++)
                        if ((1 << k) == syn) res.check[k+1] = ~res.check[k+1];
                end else begin
                    d = 0;
                    for (int p = 3; p < syn; p++)
                        if ((p & (p - 1)) != 0) d++;
                    res.data[d] = ~res.data[d];
                end
            end
        end
        return res;
    endfunction

    // mostly valid codewords with 0/1/2 flipped bits; the rest encodes and noise
    task automatic random_request(input logic [LEN_W-1:0] cfg_len, output logic req,
                                  output logic [DATA_W-1:0] din, output logic [CHK_W-1:0] cin);
        int unsigned len, np, kind, flips, prev, pos;
        t_codec_result enc;
        codeword_dims(cfg_len, len, np);
        kind = $urandom_range(99);
        din = {$urandom, $urandom};
        cin = CHK_W'($urandom);
        req = (kind < 25) ? REQ_ENCODE : REQ_DECODE;
        if (kind >= 25 && kind < 85) begin
            enc = secded_compute(cfg_len, REQ_ENCODE, din, cin);
            cin = enc.check | (cin & ~CHK_W'((1 << (np + 1)) - 1));
            flips = (kind < 45) ? 0 : (kind < 70) ? 1 : 2;
            prev = len + np + 1;
            for (int f = 0; f < flips; f++) begin
                pos = prev;
                while (pos == prev) pos = $urandom_range(len + np);
                prev = pos;
                if (pos < len) din[pos] = ~din[pos];
                else cin[pos-len] = ~cin[pos-len];
            end
        end
    endtask

    task automatic send_request(input logic req, input logic [DATA_W-1:0] din,
                                input logic [CHK_W-1:0] cin, input t_codec_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_data_bits  <= din;
        i_check_bits <= cin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        codec_results_due.push_back(want);
    endtask

    // register writes only once the pipe has drained
    task automatic write_length(input logic [LEN_W-1:0] val);
        i_valid <= 1'b0;
        while (codec_results_due.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_len = val;
    endtask

    function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_codec_result want;
        i_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (codec_results_due.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual %0h %0h %0d %0d",
                         $time, o_out_data, o_out_check, o_status, o_error_position);
                fail_count++;
            end else begin
                want = codec_results_due.pop_front();
                check_field("out_data", want.data, o_out_data);
                check_field("out_check", want.check, o_out_check);
                check_field("status", want.status, o_status);
                check_field("error_position", want.epos, o_error_position);
            end
        end
    end

    initial begin
        t_codec_result     want;
        logic              req;
        logic [DATA_W-1:0] din;
        logic [CHK_W-1:0]  cin;
        int                drain_cycles;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[i]) begin
            if (DIR_TAB[i].len != cur_len) write_length(DIR_TAB[i].len);
            if (DIR_TAB[i].typed) want = DIR_TAB[i].want;
            else want = secded_compute(cur_len, DIR_TAB[i].req, DIR_TAB[i].data,
                                       DIR_TAB[i].check);
            send_request(DIR_TAB[i].req, DIR_TAB[i].data, DIR_TAB[i].check, want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_length(PHASE_LEN[ph]);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 81;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 81;
                end
                default: begin
                    send_idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                random_request(cur_len, req, din, cin);
                send_request(req, din, cin, secded_compute(cur_len, req, din, cin));
            end
        end
        i_valid <= 1'b0;

        drain_cycles = 0;
        while (codec_results_due.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (codec_results_due.size() != 0) begin
            $display("%0t: results missing, expected %0d more actual 0",
                     $time, codec_results_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
